### src/psm_pkg.sv
// ----------------------------------------------------------------------------
// psm_pkg
// Shared types, signature tables and helpers of the payload signature matcher.
// ----------------------------------------------------------------------------
package psm_pkg;

  localparam int MaxSigLen = 14;
  localparam int HistDepth = MaxSigLen - 1;
  localparam int NumPhp    = 8;
  localparam int NumXss    = 6;

  localparam int ByteW  = 8;
  localparam int CountW = 16;

  localparam logic [CountW-1:0] ScanLimitReset = 16'd2048;
  localparam logic [CountW-1:0] CountMax       = 16'hFFFF;

  // signature text, last char in the low byte: byte k is k positions before the newest
  localparam logic [ByteW*MaxSigLen-1:0] PhpSigs [NumPhp] = '{
    "eval(", {"base64", "_decode("}, "system(", "passthru(",
    "exec(", {"shell", "_exec("}, "popen(", {"proc", "_open("}
  };
  localparam int PhpLens [NumPhp] = '{5, 14, 7, 9, 5, 11, 6, 10};

  localparam logic [ByteW*MaxSigLen-1:0] XssSigs [NumXss] = '{
    "<script>", "javascript:", "onerror=", "onload=", "<img", "alert("
  };
  localparam int XssLens [NumXss] = '{8, 11, 8, 7, 4, 6};

  typedef enum logic [1:0] {
    THREAT_NONE   = 2'd0,
    THREAT_PHP    = 2'd1,
    THREAT_SCRIPT = 2'd2
  } threat_class_e;

  localparam logic [4:0] PenaltyPhp  = 5'd25;
  localparam logic [4:0] PenaltyXss  = 5'd10;
  localparam logic [4:0] PenaltyNone = 5'd0;

  typedef struct packed {
    logic [NumPhp-1:0] php;
    logic [NumXss-1:0] xss;
  } hits_t;

  typedef struct packed {
    threat_class_e threat_class;
    logic [2:0]    signature_index;
    logic          critical;
    logic [4:0]    reputation_penalty;
  } result_t;

  // ascii upper case to lower case, other bytes unchanged
  function automatic logic [ByteW-1:0] fold(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

### src/psm_in_if.sv
// ----------------------------------------------------------------------------
// psm_in_if
// Payload byte channel: one item is one payload byte plus its end marker.
// ----------------------------------------------------------------------------
interface psm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;

  modport source (output valid, output payload_byte, output last_byte, input ready);
  modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

### src/psm_out_if.sv
// ----------------------------------------------------------------------------
// psm_out_if
// Verdict channel: one item per packet.
// ----------------------------------------------------------------------------
interface psm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] threat_class;
  logic [2:0] signature_index;
  logic       critical;
  logic [4:0] reputation_penalty;

  modport source (output valid, output threat_class, output signature_index,
                  output critical, output reputation_penalty, input ready);
  modport sink   (input valid, input threat_class, input signature_index,
                  input critical, input reputation_penalty, output ready);
endinterface

### src/psm_window_match.sv
// ----------------------------------------------------------------------------
// psm_window_match
// Parallel comparators: which signatures end at the newest byte of the window.
// ----------------------------------------------------------------------------
module psm_window_match (
  input  logic [psm_pkg::ByteW-1:0] win_i [psm_pkg::MaxSigLen],
  output psm_pkg::hits_t            hits_o
);

  always_comb begin
    hits_o = '0;
    for (int i = 0; i < psm_pkg::NumPhp; i++) begin
      hits_o.php[i] = 1'b1;
      for (int k = 0; k < psm_pkg::MaxSigLen; k++) begin
        if (k < psm_pkg::PhpLens[i] &&
            win_i[k] != psm_pkg::PhpSigs[i][psm_pkg::ByteW*k +: psm_pkg::ByteW]) begin
          hits_o.php[i] = 1'b0;
        end
      end
    end
    // xss compare is case-insensitive
    for (int i = 0; i < psm_pkg::NumXss; i++) begin
      hits_o.xss[i] = 1'b1;
      for (int k = 0; k < psm_pkg::MaxSigLen; k++) begin
        if (k < psm_pkg::XssLens[i] &&
            psm_pkg::fold(win_i[k]) !=
              psm_pkg::XssSigs[i][psm_pkg::ByteW*k +: psm_pkg::ByteW]) begin
          hits_o.xss[i] = 1'b0;
        end
      end
    end
  end

endmodule

### src/psm_verdict.sv
// ----------------------------------------------------------------------------
// psm_verdict
// Priority pick of the first php signature, else the first xss signature.
// ----------------------------------------------------------------------------
module psm_verdict (
  input  psm_pkg::hits_t   flags_i,
  output psm_pkg::result_t result_o
);

  always_comb begin
    result_o = '{threat_class:       psm_pkg::THREAT_NONE,
                 signature_index:    3'd0,
                 critical:           1'b0,
                 reputation_penalty: psm_pkg::PenaltyNone};
    if (flags_i.php != '0) begin
      result_o.threat_class       = psm_pkg::THREAT_PHP;
      result_o.critical           = 1'b1;
      result_o.reputation_penalty = psm_pkg::PenaltyPhp;
      // descending scan so the lowest set bit wins
      for (int i = psm_pkg::NumPhp - 1; i >= 0; i--) begin
        if (flags_i.php[i]) begin
          result_o.signature_index = 3'(i);
        end
      end
    end else if (flags_i.xss != '0) begin
      result_o.threat_class       = psm_pkg::THREAT_SCRIPT;
      result_o.reputation_penalty = psm_pkg::PenaltyXss;
      for (int i = psm_pkg::NumXss - 1; i >= 0; i--) begin
        if (flags_i.xss[i]) begin
          result_o.signature_index = 3'(i);
        end
      end
    end
  end

endmodule

### src/payload_signature_matcher_top.sv
// ----------------------------------------------------------------------------
// payload_signature_matcher_top
// Scans the leading bytes of each packet payload for php-shell and xss
// signatures and gives one verdict item on the last byte.
// ----------------------------------------------------------------------------
// the verdict of a last byte held in stage 0 is registered into the output register as that byte leaves
// throughput: 1 byte per cycle, set by the history/flag update; a last byte waits while the verdict slot is busy
// a verdict waiting in the output register does not block non-last bytes
// reset: async active low; clears history, hit flags, byte count and valids,
// scan_limit returns to 2048
module payload_signature_matcher_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [psm_pkg::CountW-1:0]  cfg_wdata_i,
  psm_in_if.sink                      in_i,
  psm_out_if.source                   out_o
);

  // configuration
  logic [psm_pkg::CountW-1:0] scan_limit_q;

  // input register stage
  logic                      s0_valid_q, s0_valid_d;
  logic [psm_pkg::ByteW-1:0] s0_byte_q;
  logic                      s0_last_q;

  // per-packet scan state
  logic [psm_pkg::ByteW-1:0]  hist_q [psm_pkg::HistDepth];
  logic [psm_pkg::ByteW-1:0]  hist_d [psm_pkg::HistDepth];
  psm_pkg::hits_t             flags_q, flags_d;
  logic [psm_pkg::CountW-1:0] seen_q, seen_d;

  // result register
  logic             out_valid_q, out_valid_d;
  psm_pkg::result_t out_res_q;

  logic [psm_pkg::ByteW-1:0] win [psm_pkg::MaxSigLen];
  psm_pkg::hits_t            hits;
  psm_pkg::hits_t            flags_upd;
  psm_pkg::result_t          verdict;
  logic                      out_free;
  logic                      s0_fire;
  logic                      examine;
  logic                      in_fire;

  // the held byte leaves stage 0 unless it is a last byte and the verdict slot is busy
  assign out_free   = !out_valid_q || out_o.ready;
  assign s0_fire    = s0_valid_q && (!s0_last_q || out_free);
  assign in_i.ready = !s0_valid_q || s0_fire;
  assign in_fire    = in_i.valid && in_i.ready;
  assign examine    = seen_q < scan_limit_q;

  // sliding window: newest byte first, then history
  always_comb begin
    win[0] = s0_byte_q;
    for (int k = 1; k < psm_pkg::MaxSigLen; k++) begin
      win[k] = hist_q[k-1];
    end
  end

  psm_window_match u_match (
    .win_i  (win),
    .hits_o (hits)
  );

  // flags including this byte feed the verdict so a signature ending on the last byte counts
  assign flags_upd = examine ? (flags_q | hits) : flags_q;

  psm_verdict u_verdict (
    .flags_i  (flags_upd),
    .result_o (verdict)
  );

  always_comb begin
    hist_d  = hist_q;
    flags_d = flags_q;
    seen_d  = seen_q;
    if (s0_fire) begin
      if (s0_last_q) begin
        // end of packet: start the next one clean
        for (int k = 0; k < psm_pkg::HistDepth; k++) begin
          hist_d[k] = '0;
        end
        flags_d = '0;
        seen_d  = '0;
      end else begin
        flags_d = flags_upd;
        if (examine) begin
          hist_d[0] = s0_byte_q;
          for (int k = 1; k < psm_pkg::HistDepth; k++) begin
            hist_d[k] = hist_q[k-1];
          end
        end
        if (seen_q != psm_pkg::CountMax) begin
          seen_d = seen_q + 16'd1;
        end
      end
    end
  end

  always_comb begin
    s0_valid_d = s0_valid_q;
    if (in_fire) begin
      s0_valid_d = 1'b1;
    end else if (s0_fire) begin
      s0_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s0_fire && s0_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_limit_q <= psm_pkg::ScanLimitReset;
      s0_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      flags_q      <= '0;
      seen_q       <= '0;
      for (int k = 0; k < psm_pkg::HistDepth; k++) begin
        hist_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        scan_limit_q <= cfg_wdata_i;
      end
      s0_valid_q  <= s0_valid_d;
      out_valid_q <= out_valid_d;
      flags_q     <= flags_d;
      seen_q      <= seen_d;
      hist_q      <= hist_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s0_byte_q <= in_i.payload_byte;
      s0_last_q <= in_i.last_byte;
    end
    if (s0_fire && s0_last_q) begin
      out_res_q <= verdict;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.threat_class       = out_res_q.threat_class;
  assign out_o.signature_index    = out_res_q.signature_index;
  assign out_o.critical           = out_res_q.critical;
  assign out_o.reputation_penalty = out_res_q.reputation_penalty;

endmodule

### src/psm_checker.sv
// ----------------------------------------------------------------------------
// psm_checker
// Port-level checks of the verdict channel, bound to the top level.
// ----------------------------------------------------------------------------
module psm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] threat_class_i,
  input logic [2:0] signature_index_i,
  input logic       critical_i,
  input logic [4:0] reputation_penalty_i
);

  // a stalled verdict stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(threat_class_i) &&
      $stable(signature_index_i) && $stable(reputation_penalty_i))
    else $error("verdict changed while stalled");

  // no verdict without a class but with a score
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && threat_class_i == psm_pkg::THREAT_NONE |->
      signature_index_i == 3'd0 && !critical_i &&
      reputation_penalty_i == psm_pkg::PenaltyNone)
    else $error("none verdict with nonzero fields");

  a_php_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && threat_class_i == psm_pkg::THREAT_PHP |->
      critical_i && reputation_penalty_i == psm_pkg::PenaltyPhp)
    else $error("php verdict fields wrong");

  a_xss_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && threat_class_i == psm_pkg::THREAT_SCRIPT |->
      !critical_i && reputation_penalty_i == psm_pkg::PenaltyXss &&
      signature_index_i < 3'(psm_pkg::NumXss))
    else $error("xss verdict fields wrong");

  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> threat_class_i <= 2'(psm_pkg::THREAT_SCRIPT))
    else $error("threat class out of range");

endmodule

bind payload_signature_matcher_top psm_checker u_psm_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .threat_class_i       (out_o.threat_class),
  .signature_index_i    (out_o.signature_index),
  .critical_i           (out_o.critical),
  .reputation_penalty_i (out_o.reputation_penalty)
);

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for payload_signature_matcher_top. Whole packets are
// pushed through the byte channel, first from a table of short directed
// packets (signature texts, case folding, scan limits 0, 1, 4, 5, 2048 and
// 65535), then random packets built mostly from mutated signatures. An
// in-bench matcher computes the verdict of every packet and each verdict item
// from the block is checked field by field, in order. Both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // run ends with a fail well past the slowest legal run
  localparam int CycleLimit = 1_000_000;
  // cycles granted to the block after the verdict queue runs dry
  localparam int DrainCycles = 8;
  // random bytes offered under each scan limit
  localparam int PhaseBytes = 40;

  typedef logic [psm_pkg::ByteW-1:0] byte_q_t [$];

  // one directed packet: scan limit in force, text, and the verdict if obvious
  typedef struct {
    logic [psm_pkg::CountW-1:0] limit;
    string                      text;
    bit                         known;
    psm_pkg::threat_class_e     cls;
    logic [2:0]                 idx;
  } packet_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [psm_pkg::CountW-1:0] cfg_wdata_i;

  psm_in_if  in_if ();
  psm_out_if out_if ();

  payload_signature_matcher_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // signature texts in table order, php matched exactly, xss case folded
  string php_text [psm_pkg::NumPhp] = '{"eval(", string'({"base64", "_decode("}),
                                        "system(", "passthru(", "exec(",
                                        string'({"shell", "_exec("}), "popen(",
                                        string'({"proc", "_open("})};
  string xss_text [psm_pkg::NumXss] = '{"<script>", "javascript:", "onerror=", "onload=",
                                        "<img", "alert("};

  // verdicts still owed by the block, oldest first
  psm_pkg::result_t verdict_q [$];

  int     mismatches;
  longint cycle_count;
  int     bytes_sent;
  int     burst_left;
  bit     gaps_on;
  int     hold_request;
  int     hold_left;
  int     pat_left;
  int     pat_mode;

  // matcher state, mirrors the block
  logic [psm_pkg::CountW-1:0] scan_lim;
  logic [psm_pkg::ByteW-1:0]  hist [psm_pkg::HistDepth];
  logic [psm_pkg::NumPhp-1:0] php_flags;
  logic [psm_pkg::NumXss-1:0] xss_flags;
  logic [psm_pkg::CountW-1:0] seen;

  // ---------------------------------------------------------------------------
  // matcher
  // ---------------------------------------------------------------------------

  function automatic logic [psm_pkg::ByteW-1:0] to_lower(
      input logic [psm_pkg::ByteW-1:0] c);
    logic [psm_pkg::ByteW-1:0] l;
    l = c;
    if (c >= "A" && c <= "Z") begin
      l = c + 8'd32;
    end
    return l;
  endfunction

  // win[0] is the newest byte; the text must end exactly on it
  function automatic bit sig_ends_here(
      input logic [psm_pkg::ByteW-1:0] win [psm_pkg::MaxSigLen],
      input string sig, input bit fold_case);
    bit                        hit;
    logic [psm_pkg::ByteW-1:0] h;
    logic [psm_pkg::ByteW-1:0] s;
    int                        n;
    hit = 1'b1;
    n = sig.len();
    for (int j = 0; j < n; j++) begin
      h = win[n-1-j];
      s = sig[j];
      if (fold_case) begin
        h = to_lower(h);
      end
      if (h != s) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

  function automatic psm_pkg::result_t verdict_for(input psm_pkg::threat_class_e cls,
                                                   input logic [2:0] idx);
    psm_pkg::result_t v;
    v.threat_class       = cls;
    v.signature_index    = (cls == psm_pkg::THREAT_NONE) ? 3'd0 : idx;
    v.critical           = (cls == psm_pkg::THREAT_PHP);
    v.reputation_penalty = (cls == psm_pkg::THREAT_PHP)    ? psm_pkg::PenaltyPhp :
                           (cls == psm_pkg::THREAT_SCRIPT) ? psm_pkg::PenaltyXss :
                                                             psm_pkg::PenaltyNone;
    return v;
  endfunction

  function automatic void clear_packet_state();
    foreach (hist[k]) hist[k] = '0;
    php_flags = '0;
    xss_flags = '0;
    seen      = '0;
  endfunction

  // advance the matcher by one accepted byte; a verdict comes on the last one
  function automatic void scan_byte(input logic [psm_pkg::ByteW-1:0] b, input bit last,
                                    output bit has, output psm_pkg::result_t v);
    logic [psm_pkg::ByteW-1:0] win [psm_pkg::MaxSigLen];
    int                        php_first;
    int                        xss_first;
    win[0] = b;
    for (int k = 1; k < psm_pkg::MaxSigLen; k++) win[k] = hist[k-1];
    // bytes past the limit neither match nor enter the history
    if (seen < scan_lim) begin
      for (int i = 0; i < psm_pkg::NumPhp; i++) begin
        if (sig_ends_here(win, php_text[i], 1'b0)) php_flags[i] = 1'b1;
      end
      for (int i = 0; i < psm_pkg::NumXss; i++) begin
        if (sig_ends_here(win, xss_text[i], 1'b1)) xss_flags[i] = 1'b1;
      end
      for (int k = psm_pkg::HistDepth - 1; k > 0; k--) hist[k] = hist[k-1];
      hist[0] = b;
    end
    if (seen != psm_pkg::CountMax) begin
      seen = seen + 1'b1;
    end
    has = last;
    v = verdict_for(psm_pkg::THREAT_NONE, 3'd0);
    if (last) begin
      // lowest set flag wins, php before xss
      php_first = -1;
      xss_first = -1;
      for (int i = psm_pkg::NumPhp - 1; i >= 0; i--) if (php_flags[i]) php_first = i;
      for (int i = psm_pkg::NumXss - 1; i >= 0; i--) if (xss_flags[i]) xss_first = i;
      if (php_first >= 0) begin
        v = verdict_for(psm_pkg::THREAT_PHP, 3'(php_first));
      end else if (xss_first >= 0) begin
        v = verdict_for(psm_pkg::THREAT_SCRIPT, 3'(xss_first));
      end
      clear_packet_state();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // byte sender
  // ---------------------------------------------------------------------------

  // offer one byte, with a random idle gap (possibly empty) first when gaps are on and the current burst is used up
  task automatic send_item(input logic [psm_pkg::ByteW-1:0] b, input bit last,
                           output bit has, output psm_pkg::result_t v);
    int gap;
    if (gaps_on && burst_left <= 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_if.valid        <= 1'b1;
    in_if.payload_byte <= b;
    in_if.last_byte    <= last;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    burst_left--;
    bytes_sent++;
    scan_byte(b, last, has, v);
  endtask

  // send a packet; a typed verdict, where given, stands in for the matcher's
  task automatic send_packet(input byte_q_t pkt, input bit known,
                             input psm_pkg::result_t typed);
    bit               has;
    psm_pkg::result_t v;
    for (int i = 0; i < pkt.size(); i++) begin
      send_item(pkt[i], i == pkt.size() - 1, has, v);
      if (has) begin
        verdict_q.push_back(known ? typed : v);
      end
    end
  endtask

  // idle until every owed verdict has come back
  task automatic wait_drained();
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  // scan_limit changes only with no packet in flight and no verdict owed
  task automatic write_scan_limit(input logic [psm_pkg::CountW-1:0] lim);
    in_if.valid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    scan_lim = lim;
  endtask

  // ---------------------------------------------------------------------------
  // random packets
  // ---------------------------------------------------------------------------

  // mostly signature pieces with flipped case, dropped or damaged bytes,
  // mixed with filler; one packet in five is pure noise
  function automatic byte_q_t random_packet();
    byte_q_t                   pkt;
    string                     sig;
    int                        sel;
    int                        drop;
    logic [psm_pkg::ByteW-1:0] c;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom_range(0, 255)));
      return pkt;
    end
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom_range(0, 255)));
      end else begin
        sel  = $urandom_range(0, psm_pkg::NumPhp + psm_pkg::NumXss - 1);
        sig  = (sel < psm_pkg::NumPhp) ? php_text[sel] : xss_text[sel - psm_pkg::NumPhp];
        drop = ($urandom_range(0, 7) == 0) ? $urandom_range(0, sig.len() - 1) : -1;
        for (int j = 0; j < sig.len(); j++) begin
          c = sig[j];
          if ((c | 8'h20) >= "a" && (c | 8'h20) <= "z" && $urandom_range(0, 5) == 0) begin
            c = c ^ 8'h20;
          end
          if ($urandom_range(0, 31) == 0) begin
            c = 8'($urandom_range(0, 255));
          end
          if (j != drop) begin
            pkt.push_back(c);
          end
        end
      end
    end
    return pkt;
  endfunction

  // ---------------------------------------------------------------------------
  // verdict receiver: long hold on request, otherwise a changing stall pattern
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (pat_left <= 0) begin
      pat_mode = $urandom_range(0, 3);
      pat_left = $urandom_range(8, 80);
    end else begin
      pat_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (pat_mode)
        0: begin
          out_if.ready <= 1'b1;
        end
        1: begin
          out_if.ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          out_if.ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_if.ready <= ($urandom_range(0, 7) != 0);
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  function automatic void log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endfunction

  always @(posedge clk_i) begin
    psm_pkg::result_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (verdict_q.size() == 0) begin
        log_mismatch($sformatf("verdict with none owed: class %0d index %0d",
                               out_if.threat_class, out_if.signature_index));
      end else begin
        want = verdict_q.pop_front();
        if (out_if.threat_class !== want.threat_class ||
            out_if.signature_index !== want.signature_index ||
            out_if.critical !== want.critical ||
            out_if.reputation_penalty !== want.reputation_penalty) begin
          log_mismatch($sformatf(
            "verdict: expected class %0d index %0d crit %0b pen %0d, got %0d %0d %0b %0d",
            want.threat_class, want.signature_index, want.critical,
            want.reputation_penalty, out_if.threat_class, out_if.signature_index,
            out_if.critical, out_if.reputation_penalty));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("payload_signature_matcher_top regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed packets
  // ---------------------------------------------------------------------------

  packet_row_t directed_rows [] = '{
    // every php text at the reset limit, one embedded in other bytes
    '{16'd2048, "eval(",           1'b1, psm_pkg::THREAT_PHP,    3'd0},
    '{16'd2048, string'({"base64", "_decode("}), 1'b1, psm_pkg::THREAT_PHP, 3'd1},
    '{16'd2048, "xsystem(y",       1'b1, psm_pkg::THREAT_PHP,    3'd2},
    '{16'd2048, "passthru(",       1'b1, psm_pkg::THREAT_PHP,    3'd3},
    // exec( ends inside the shell exec text and sits earlier in the table
    '{16'd2048, string'({"shell", "_exec("}),    1'b1, psm_pkg::THREAT_PHP, 3'd4},
    '{16'd2048, "popen(",          1'b1, psm_pkg::THREAT_PHP,    3'd6},
    '{16'd2048, string'({"proc", "_open("}),     1'b1, psm_pkg::THREAT_PHP, 3'd7},
    // xss texts in mixed case
    '{16'd2048, "<SCRIPT>",        1'b1, psm_pkg::THREAT_SCRIPT, 3'd0},
    '{16'd2048, "JavaScript:",     1'b1, psm_pkg::THREAT_SCRIPT, 3'd1},
    '{16'd2048, "onError=",        1'b1, psm_pkg::THREAT_SCRIPT, 3'd2},
    '{16'd2048, "OnLoad=",         1'b1, psm_pkg::THREAT_SCRIPT, 3'd3},
    '{16'd2048, "<iMg",            1'b1, psm_pkg::THREAT_SCRIPT, 3'd4},
    '{16'd2048, "ALERT(",          1'b1, psm_pkg::THREAT_SCRIPT, 3'd5},
    // php is case sensitive
    '{16'd2048, "EVAL(",           1'b1, psm_pkg::THREAT_NONE,   3'd0},
    // php outranks xss
    '{16'd2048, "alert(eval(",     1'b1, psm_pkg::THREAT_PHP,    3'd0},
    // table order, not arrival order
    '{16'd2048, "onload=<script>", 1'b0, psm_pkg::THREAT_NONE,   3'd0},
    // high bytes and the neighbors of the letter ranges
    '{16'd2048, "\377\200~Z@[`{",  1'b1, psm_pkg::THREAT_NONE,   3'd0},
    // scan limit cuts through or just covers the text
    '{16'd1,    "eval(",           1'b1, psm_pkg::THREAT_NONE,   3'd0},
    '{16'd5,    "eval(",           1'b1, psm_pkg::THREAT_PHP,    3'd0},
    '{16'd4,    "eval(",           1'b1, psm_pkg::THREAT_NONE,   3'd0},
    // zero limit examines nothing
    '{16'd0,    "<img",            1'b1, psm_pkg::THREAT_NONE,   3'd0},
    // no match across the packet boundary
    '{16'hFFFF, "eval",            1'b1, psm_pkg::THREAT_NONE,   3'd0},
    '{16'hFFFF, "(",               1'b1, psm_pkg::THREAT_NONE,   3'd0},
    '{16'hFFFF, string'({"base64", "_decodE("}), 1'b0, psm_pkg::THREAT_NONE, 3'd0}
  };

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    byte_q_t                    pkt;
    psm_pkg::result_t           dont_care;
    logic [psm_pkg::CountW-1:0] lim;
    string                      sig;
    int                         phase_base;
    bit                         paused;

    // block inputs known from time zero, ready from the first edge, reset held low
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    in_if.valid        <= 1'b0;
    in_if.payload_byte <= '0;
    in_if.last_byte    <= 1'b0;
    mismatches   = 0;
    cycle_count  = 0;
    bytes_sent   = 0;
    burst_left   = 0;
    gaps_on      = 1'b1;
    hold_request = 0;
    hold_left    = 0;
    pat_left     = 0;
    pat_mode     = 0;
    dont_care    = verdict_for(psm_pkg::THREAT_NONE, 3'd0);
    scan_lim     = psm_pkg::ScanLimitReset;
    clear_packet_state();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; the first rows run on the reset value of scan_limit
    foreach (directed_rows[r]) begin
      if (directed_rows[r].limit != scan_lim) begin
        write_scan_limit(directed_rows[r].limit);
      end
      pkt.delete();
      sig = directed_rows[r].text;
      for (int i = 0; i < sig.len(); i++) pkt.push_back(sig[i]);
      send_packet(pkt, directed_rows[r].known,
                  verdict_for(directed_rows[r].cls, directed_rows[r].idx));
    end

    // random phases, each under its own scan limit
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: lim = 16'd2048;
        1: lim = 16'd1;
        2: lim = 16'($urandom_range(2, 30));
        3: lim = 16'hFFFF;
        4: lim = 16'd0;
        5: lim = 16'($urandom_range(0, 65535));
        6: lim = 16'($urandom_range(6, 20));
        default: lim = 16'hFFFF;
      endcase
      write_scan_limit(lim);
      // one phase runs with the sender never idling
      gaps_on    = (phase != 3);
      phase_base = bytes_sent;
      paused     = 1'b0;

      if (phase == 2) begin
        // receiver holds off while short packets keep coming: the output
        // register fills and the next last byte must stall the input
        hold_request = 300;
        repeat (25) begin
          pkt.delete();
          repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom_range(0, 255)));
          send_packet(pkt, 1'b0, dont_care);
        end
      end

      while (bytes_sent - phase_base < PhaseBytes) begin
        send_packet(random_packet(), 1'b0, dont_care);
        if (phase == 5 && !paused && bytes_sent - phase_base >= PhaseBytes / 2) begin
          // sender goes quiet until every owed verdict is in
          paused = 1'b1;
          in_if.valid <= 1'b0;
          wait_drained();
          @(posedge clk_i);
        end
      end
    end

    in_if.valid <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    mismatches += verdict_q.size();
    if (mismatches == 0) begin
      $display("payload_signature_matcher_top regression: pass");
    end else begin
      $display("payload_signature_matcher_top regression: fail");
    end
    $finish;
  end

endmodule

### payload_signature_matcher_top.f
src/psm_pkg.sv
src/psm_in_if.sv
src/psm_out_if.sv
src/psm_window_match.sv
src/psm_verdict.sv
src/payload_signature_matcher_top.sv
src/psm_checker.sv
verif/tb_top.sv
